@@ hw/rtl/acsp_pkg.sv @@
// acsp_pkg: shared types, kind codes and keyword constants of the command stream parser
// no dependencies; imported by every module of the parser
package acsp_pkg;

	// result kinds
	localparam logic [2:0] KIND_SINE  = 3'd0;
	localparam logic [2:0] KIND_PHASE = 3'd1;
	localparam logic [2:0] KIND_FREQ  = 3'd2;
	localparam logic [2:0] KIND_AMPL  = 3'd3;
	localparam logic [2:0] KIND_OFST  = 3'd4;
	localparam logic [2:0] KIND_OUTEN = 3'd5;
	localparam logic [2:0] KIND_IDN   = 3'd6;
	localparam logic [2:0] KIND_WAVEQ = 3'd7;

	// channel codes
	localparam logic [1:0] CHAN_ONE = 2'd1;
	localparam logic [1:0] CHAN_TWO = 2'd2;

	// byte window, newest byte in the low bits
	localparam int WIN_BYTES = 13;
	localparam int WIN_BITS  = 8 * WIN_BYTES;

	// keywords, last character in the low byte
	localparam logic [103:0] KW_IDN   = "IDN-SGLT-PRI?";
	localparam logic [39:0]  KW_BSWVQ = "BSWV?";
	localparam logic [23:0]  KW_C1    = "C1:";
	localparam logic [23:0]  KW_C2    = "C2:";
	localparam logic [39:0]  KW_WVTP  = "WVTP,";
	localparam logic [39:0]  KW_SINE  = "SINE,";
	localparam logic [39:0]  KW_PHSE  = "PHSE,";
	localparam logic [31:0]  KW_FRQ   = "FRQ,";
	localparam logic [31:0]  KW_AMP   = "AMP,";
	localparam logic [39:0]  KW_OFST  = "OFST,";
	localparam logic [15:0]  KW_ON    = "ON";
	localparam logic [23:0]  KW_OFF   = "OFF";

	// magnitude cap, 2^32
	localparam int MAG_BITS = 33;
	localparam logic [MAG_BITS-1:0] MAG_CAP = 33'h1_0000_0000;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [1:0]         channel;
		logic signed [31:0] value;
		logic               final_result;
	} out_item_t;

	// result before decimal scaling and clamping
	typedef struct packed {
		logic [2:0]          kind;
		logic [1:0]          channel;
		logic [MAG_BITS-1:0] mag;
		logic [1:0]          missing;
		logic                neg;
		logic                final_result;
	} raw_t;

	// results produced by one parsed byte
	typedef struct packed {
		logic [1:0] count;
		raw_t       r0;
		raw_t       r1;
	} push_t;

	// 10^missing for the dropped fraction digits
	function automatic logic [9:0] pow10(input logic [1:0] missing);
		logic [9:0] f;
		case (missing)
			2'd0: f = 10'd1;
			2'd1: f = 10'd10;
			2'd2: f = 10'd100;
			default: f = 10'd1000;
		endcase
		return f;
	endfunction

endpackage

@@ hw/rtl/awg_command_stream_parser.sv @@
// awg_command_stream_parser: top level of the generator command stream parser
// depends on acsp_pkg, acsp_parse, acsp_fifo and acsp_scale
//
// One ASCII byte of a command message is taken per cmd transfer, with
// end_of_message on the final byte. A 13-byte window is compared against
// the keyword set after every byte, so keywords are found wherever they
// end. C1:/C2: pick the channel (1 at the start of each message), WVTP,
// followed directly by SINE, gives a sine result, ON/OFF give output enable
// 1/0, PHSE, OFST, (x100) and FRQ, AMP, (x1000) start a signed decimal that
// is written out when a non-number byte or the end of the message arrives,
// saturated to 32 bits. IDN-SGLT-PRI? and BSWV? give read requests and mute
// the rest of the message. The keyword compare and number update run on the
// byte held in the input register, and a byte is accepted every cycle while
// the four-entry result queue has room for two results. Results then pass
// through one scaling multiplier into the output register, one res transfer
// per cycle while res_stall is low. A byte that makes two results needs two
// res transfers; the queue absorbs this and cmd_stall rises only when it is
// nearly full. No clearing pass after reset.
module awg_command_stream_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  acsp_pkg::in_item_t  cmd,
	output logic                res_valid,
	input  logic                res_stall,
	output acsp_pkg::out_item_t res
);
	import acsp_pkg::*;

	// parser to queue
	push_t push;
	logic  room;

	// queue to output stage
	logic  head_valid;
	raw_t  head;
	logic  pop;

	// byte window, keyword match and number accumulation
	acsp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.room      (room),
		.push      (push)
	);

	// holds results until the output side takes them
	acsp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// scale by the missing fraction digits, clamp, register the result
	acsp_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

endmodule

@@ hw/rtl/acsp_parse.sv @@
// acsp_parse: input register, parser state and keyword/number logic
// depends on acsp_pkg; feeds up to two raw results per byte into the result queue
module acsp_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  acsp_pkg::in_item_t cmd,
	input  logic              room,
	output acsp_pkg::push_t   push
);
	import acsp_pkg::*;

	localparam logic [7:0] CH_0     = "0";
	localparam logic [7:0] CH_9     = "9";
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_DOT   = ".";

	logic           valid_s1;
	in_item_t       item_s1;
	logic           go;

	logic [WIN_BITS-1:0] win_q, win_n;
	logic [3:0]          mp_q, mp_n;
	logic [1:0]          chan_q, chan_n;
	logic [2:0]          kind_q, kind_n;
	logic                active_q, active_n;
	logic [MAG_BITS-1:0] acc_q, acc_n;
	logic                neg_q, neg_n;
	logic [1:0]          fc_q, fc_n;
	logic                dot_q, dot_n;
	logic                awt_q, awt_n;
	logic                done_q, done_n;

	logic [7:0]  c;
	logic [3:0]  digit;
	logic [36:0] acc_next;
	logic        is_digit;
	logic        kw_emit;
	raw_t        kw_res;
	push_t       p;

	function automatic logic [1:0] allowed_frac(input logic [2:0] k);
		return (k == KIND_FREQ || k == KIND_AMPL) ? 2'd3 : 2'd2;
	endfunction

	function automatic raw_t mk_num(input logic [2:0] k, input logic [1:0] ch,
			input logic [MAG_BITS-1:0] m, input logic [1:0] f, input logic ng);
		raw_t r;
		r.kind         = k;
		r.channel      = ch;
		r.mag          = m;
		r.missing      = allowed_frac(k) - f;
		r.neg          = ng;
		r.final_result = 1'b0;
		return r;
	endfunction

	function automatic raw_t mk_fixed(input logic [2:0] k, input logic [1:0] ch,
			input logic v);
		raw_t r;
		r.kind         = k;
		r.channel      = ch;
		r.mag          = {{(MAG_BITS-1){1'b0}}, v};
		r.missing      = 2'd0;
		r.neg          = 1'b0;
		r.final_result = 1'b0;
		return r;
	endfunction

	assign go        = valid_s1 && room;
	assign cmd_stall = valid_s1 && !room;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			item_s1 <= cmd;
		end
	end

	assign c        = item_s1.char_in;
	assign digit    = 4'(c - CH_0);
	assign is_digit = (c >= CH_0) && (c <= CH_9);
	assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {33'd0, digit};

	always_comb begin
		win_n    = win_q;
		mp_n     = mp_q;
		chan_n   = chan_q;
		kind_n   = kind_q;
		active_n = active_q;
		acc_n    = acc_q;
		neg_n    = neg_q;
		fc_n     = fc_q;
		dot_n    = dot_q;
		awt_n    = awt_q;
		done_n   = done_q;
		kw_emit  = 1'b0;
		kw_res   = mk_fixed(KIND_SINE, chan_q, 1'b0);
		p        = '0;

		if (!done_q) begin
			win_n = {win_q[WIN_BITS-9:0], c};
			mp_n  = (mp_q == 4'd15) ? mp_q : mp_q + 4'd1;
			if (mp_n > 4'd5) begin
				awt_n = 1'b0;
			end

			// number digits
			if (active_q) begin
				if (c == CH_MINUS && mp_n == 4'd1) begin
					neg_n = 1'b1;
				end else if (is_digit) begin
					if (!dot_q || fc_q < allowed_frac(kind_q)) begin
						acc_n = (acc_next > 37'(MAG_CAP)) ? MAG_CAP : acc_next[MAG_BITS-1:0];
						if (dot_q) begin
							fc_n = fc_q + 2'd1;
						end
					end
				end else if (c == CH_DOT && !dot_q) begin
					dot_n = 1'b1;
				end else begin
					p.r0     = mk_num(kind_q, chan_q, acc_q, fc_q, neg_q);
					p.count  = 2'd1;
					active_n = 1'b0;
				end
			end

			// keyword match, first hit in priority order wins
			if (win_n[$bits(KW_IDN)-1:0] == KW_IDN) begin
				kw_emit = 1'b1;
				kw_res  = mk_fixed(KIND_IDN, chan_q, 1'b0);
				done_n  = 1'b1;
			end else if (win_n[$bits(KW_BSWVQ)-1:0] == KW_BSWVQ) begin
				kw_emit = 1'b1;
				kw_res  = mk_fixed(KIND_WAVEQ, chan_q, 1'b0);
				done_n  = 1'b1;
			end else if (win_n[$bits(KW_C1)-1:0] == KW_C1) begin
				chan_n = CHAN_ONE;
			end else if (win_n[$bits(KW_C2)-1:0] == KW_C2) begin
				chan_n = CHAN_TWO;
			end else if (win_n[$bits(KW_WVTP)-1:0] == KW_WVTP) begin
				awt_n = 1'b1;
			end else if (awt_n && mp_n == 4'd5 &&
					win_n[$bits(KW_SINE)-1:0] == KW_SINE) begin
				kw_emit = 1'b1;
				kw_res  = mk_fixed(KIND_SINE, chan_q, 1'b0);
			end else if (win_n[$bits(KW_PHSE)-1:0] == KW_PHSE) begin
				kind_n = KIND_PHASE;
			end else if (win_n[$bits(KW_FRQ)-1:0] == KW_FRQ) begin
				kind_n = KIND_FREQ;
			end else if (win_n[$bits(KW_AMP)-1:0] == KW_AMP) begin
				kind_n = KIND_AMPL;
			end else if (win_n[$bits(KW_OFST)-1:0] == KW_OFST) begin
				kind_n = KIND_OFST;
			end else if (win_n[$bits(KW_ON)-1:0] == KW_ON) begin
				kw_emit = 1'b1;
				kw_res  = mk_fixed(KIND_OUTEN, chan_q, 1'b1);
			end else if (win_n[$bits(KW_OFF)-1:0] == KW_OFF) begin
				kw_emit = 1'b1;
				kw_res  = mk_fixed(KIND_OUTEN, chan_q, 1'b0);
			end else begin
				mp_n = mp_n;
			end

			// any hit resets the progress count and clears the wave-type arm; a WVTP, hit sets the arm
			if (kw_emit || done_n || chan_n != chan_q || kind_n != kind_q ||
					(awt_n && !(awt_q && mp_n <= 4'd5)) ||
					win_n[$bits(KW_C1)-1:0] == KW_C1 ||
					win_n[$bits(KW_C2)-1:0] == KW_C2 ||
					win_n[$bits(KW_PHSE)-1:0] == KW_PHSE ||
					win_n[$bits(KW_FRQ)-1:0] == KW_FRQ ||
					win_n[$bits(KW_AMP)-1:0] == KW_AMP ||
					win_n[$bits(KW_OFST)-1:0] == KW_OFST ||
					win_n[$bits(KW_WVTP)-1:0] == KW_WVTP) begin
				mp_n = 4'd0;
				if (win_n[$bits(KW_WVTP)-1:0] != KW_WVTP ||
						win_n[$bits(KW_IDN)-1:0] == KW_IDN ||
						win_n[$bits(KW_BSWVQ)-1:0] == KW_BSWVQ ||
						win_n[$bits(KW_C1)-1:0] == KW_C1 ||
						win_n[$bits(KW_C2)-1:0] == KW_C2) begin
					awt_n = 1'b0;
				end
			end

			// number start clears the number state
			if (win_n[$bits(KW_IDN)-1:0] != KW_IDN &&
					win_n[$bits(KW_BSWVQ)-1:0] != KW_BSWVQ &&
					win_n[$bits(KW_C1)-1:0] != KW_C1 &&
					win_n[$bits(KW_C2)-1:0] != KW_C2 &&
					win_n[$bits(KW_WVTP)-1:0] != KW_WVTP &&
					!(awt_q && mp_n == 4'd0 && 1'b0) &&
					!kw_emit &&
					(win_n[$bits(KW_PHSE)-1:0] == KW_PHSE ||
					 win_n[$bits(KW_FRQ)-1:0] == KW_FRQ ||
					 win_n[$bits(KW_AMP)-1:0] == KW_AMP ||
					 win_n[$bits(KW_OFST)-1:0] == KW_OFST)) begin
				active_n = 1'b1;
				acc_n    = '0;
				neg_n    = 1'b0;
				fc_n     = 2'd0;
				dot_n    = 1'b0;
			end

			if (kw_emit) begin
				if (p.count == 2'd0) begin
					p.r0 = kw_res;
				end else begin
					p.r1 = kw_res;
				end
				p.count = p.count + 2'd1;
			end
		end

		// end of message: flush an open number, then clear the message state
		if (item_s1.end_of_message) begin
			if (active_n && p.count != 2'd2) begin
				if (p.count == 2'd0) begin
					p.r0 = mk_num(kind_n, chan_n, acc_n, fc_n, neg_n);
				end else begin
					p.r1 = mk_num(kind_n, chan_n, acc_n, fc_n, neg_n);
				end
				p.count = p.count + 2'd1;
			end
			win_n    = '0;
			mp_n     = 4'd0;
			chan_n   = CHAN_ONE;
			kind_n   = KIND_SINE;
			active_n = 1'b0;
			acc_n    = '0;
			neg_n    = 1'b0;
			fc_n     = 2'd0;
			dot_n    = 1'b0;
			awt_n    = 1'b0;
			done_n   = 1'b0;
		end

		if (p.count == 2'd1) begin
			p.r0.final_result = 1'b1;
		end else if (p.count == 2'd2) begin
			p.r1.final_result = 1'b1;
		end

		if (!go) begin
			p.count = 2'd0;
		end
	end

	assign push = p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= '0;
			mp_q     <= 4'd0;
			chan_q   <= CHAN_ONE;
			kind_q   <= KIND_SINE;
			active_q <= 1'b0;
			acc_q    <= '0;
			neg_q    <= 1'b0;
			fc_q     <= 2'd0;
			dot_q    <= 1'b0;
			awt_q    <= 1'b0;
			done_q   <= 1'b0;
		end else if (go) begin
			win_q    <= win_n;
			mp_q     <= mp_n;
			chan_q   <= chan_n;
			kind_q   <= kind_n;
			active_q <= active_n;
			acc_q    <= acc_n;
			neg_q    <= neg_n;
			fc_q     <= fc_n;
			dot_q    <= dot_n;
			awt_q    <= awt_n;
			done_q   <= done_n;
		end
	end

	a_chan_legal: assert property (@(posedge clk) disable iff (!arst_n)
		chan_q == CHAN_ONE || chan_q == CHAN_TWO)
		else $error("channel register left 1..2");

	a_eom_clears: assert property (@(posedge clk) disable iff (!arst_n)
		go && item_s1.end_of_message |=> chan_q == CHAN_ONE && !active_q && !done_q)
		else $error("message state not cleared after final byte");

	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> fc_q <= allowed_frac(kind_q))
		else $error("fraction count past allowed digits");

endmodule

@@ hw/rtl/acsp_fifo.sv @@
// acsp_fifo: four-entry queue of raw results between parser and output stage
// depends on acsp_pkg; takes up to two results per cycle, gives one
module acsp_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  acsp_pkg::push_t push,
	output logic            room,
	output logic            head_valid,
	output acsp_pkg::raw_t  head,
	input  logic            pop
);
	import acsp_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	raw_t          mem [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   count_q;

	assign room       = count_q <= (AW+1)'(DEPTH - 2);
	assign head_valid = count_q != '0;
	assign head       = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wp_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem[wp_q + AW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + AW'(push.count);
			rp_q    <= rp_q + AW'(pop);
			count_q <= count_q + (AW+1)'(push.count) - (AW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(DEPTH))
		else $error("result queue overflow");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty result queue");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> room)
		else $error("push without room");

endmodule

@@ hw/rtl/acsp_scale.sv @@
// acsp_scale: decimal scaling, clamping and the output register
// depends on acsp_pkg; reads the head of the result queue
module acsp_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  acsp_pkg::raw_t      head,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_stall,
	output acsp_pkg::out_item_t res
);
	import acsp_pkg::*;

	localparam int PROD_BITS = MAG_BITS + 10;

	logic                 valid_q;
	out_item_t            res_q;
	logic                 load;
	logic [PROD_BITS-1:0] prod;
	logic [31:0]          clamped;

	assign load = !valid_q || !res_stall;
	assign pop  = head_valid && load;
	assign prod = PROD_BITS'(head.mag) * PROD_BITS'(pow10(head.missing));

	always_comb begin
		if (head.neg) begin
			clamped = (prod > PROD_BITS'(33'h0_8000_0000)) ? 32'h8000_0000
				: 32'd0 - prod[31:0];
		end else begin
			clamped = (prod > PROD_BITS'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF
				: prod[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.kind         <= head.kind;
			res_q.channel      <= head.channel;
			res_q.value        <= clamped;
			res_q.final_result <= head.final_result;
		end
	end

	assign res_valid = valid_q;
	assign res       = res_q;

endmodule

@@ test/tb.sv @@
// tb: self-checking testbench for the generator command stream parser
// depends on acsp_pkg and awg_command_stream_parser; drives command messages
// and checks every parser write against a behavioral model of the parser
`timescale 1ns / 1ps

module tb;
	import acsp_pkg::*;

	typedef enum logic [1:0] {
		PHASE_RX_BUSY,
		PHASE_TX_BUSY,
		PHASE_NO_IDLE
	} idle_phase_e;

	localparam longint unsigned ACC_LIMIT = 64'h1_0000_0000;
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_BYTES = 1450;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	in_item_t  cmd;
	logic      res_valid;
	logic      res_stall;
	out_item_t res;

	awg_command_stream_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	always #6 clk = ~clk;

	// parser model state
	logic [103:0]    win;
	int unsigned     prog;
	logic [1:0]      chan;
	logic [2:0]      num_kind;
	bit              num_on;
	bit              neg;
	bit              dot;
	bit              wave_armed;
	bit              muted;
	longint unsigned acc;
	int unsigned     frac;

	out_item_t   byte_writes[$];
	out_item_t   parser_writes[$];
	in_item_t    cmd_bytes[$];
	logic [7:0]  msg[$];

	int total_bytes;
	int bytes_sent;
	int writes_seen;
	int msg_count;
	int error_count;
	idle_phase_e idle_phase;

	string kw_text[12] = '{"IDN-SGLT-PRI?", "BSWV?", "C1:", "C2:", "WVTP,", "SINE,",
		"PHSE,", "FRQ,", "AMP,", "OFST,", "ON", "OFF"};
	string wave_names[3] = '{"SQUARE,", "RAMP,", "XSINE,"};
	string seps = ",; \n";

	function automatic bit ends_with(logic [103:0] kw, int nbytes);
		logic [103:0] mask;
		mask = {104{1'b1}} >> (8 * (WIN_BYTES - nbytes));
		return (win & mask) == kw;
	endfunction

	function automatic int unsigned frac_limit();
		return (num_kind == KIND_FREQ || num_kind == KIND_AMPL) ? 3 : 2;
	endfunction

	function automatic void add_write(logic [2:0] k, logic [31:0] v);
		out_item_t w;
		w.kind = k;
		w.channel = chan;
		w.value = v;
		w.final_result = 1'b0;
		byte_writes.push_back(w);
	endfunction

	function automatic void open_number(logic [2:0] k);
		num_on = 1;
		num_kind = k;
		acc = 0;
		neg = 0;
		frac = 0;
		dot = 0;
	endfunction

	// scale by the dropped fraction digits, then clamp to 32 bits
	function automatic void close_number();
		longint unsigned m;
		logic [63:0] t;
		int unsigned miss;
		m = acc;
		miss = frac_limit() - frac;
		repeat (miss) m = m * 10;
		t = 64'd0 - m;
		if (neg)
			add_write(num_kind, (m > 64'h8000_0000) ? 32'h8000_0000 : t[31:0]);
		else
			add_write(num_kind, (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0]);
		num_on = 0;
	endfunction

	function automatic void reset_message();
		win = '0;
		prog = 0;
		chan = CHAN_ONE;
		num_kind = KIND_SINE;
		num_on = 0;
		acc = 0;
		neg = 0;
		frac = 0;
		dot = 0;
		wave_armed = 0;
		muted = 0;
	endfunction

	// model one accepted command byte and queue the writes it causes
	task automatic parse_byte(in_item_t it);
		logic [7:0] c;
		bit found;
		bit arm;
		bit sine_ok;
		out_item_t w;
		c = it.char_in;
		byte_writes.delete();
		if (!muted) begin
			win = {win[95:0], c};
			if (prog < 15) prog++;
			if (prog > 5) wave_armed = 0;
			if (num_on) begin
				if (c == "-" && prog == 1) begin
					neg = 1;
				end else if (c >= "0" && c <= "9") begin
					if (!dot || frac < frac_limit()) begin
						acc = acc * 10 + (c - "0");
						if (acc > ACC_LIMIT) acc = ACC_LIMIT;
						if (dot) frac++;
					end
				end else if (c == "." && !dot) begin
					dot = 1;
				end else begin
					close_number();
				end
			end
			// sine counts only when it follows the wave type keyword directly
			sine_ok = wave_armed && prog == 5;
			found = 1;
			arm = 0;
			if (ends_with(KW_IDN, 13)) begin
				add_write(KIND_IDN, 0);
				muted = 1;
			end else if (ends_with(KW_BSWVQ, 5)) begin
				add_write(KIND_WAVEQ, 0);
				muted = 1;
			end else if (ends_with(KW_C1, 3)) chan = CHAN_ONE;
			else if (ends_with(KW_C2, 3)) chan = CHAN_TWO;
			else if (ends_with(KW_WVTP, 5)) arm = 1;
			else if (sine_ok && ends_with(KW_SINE, 5)) add_write(KIND_SINE, 0);
			else if (ends_with(KW_PHSE, 5)) open_number(KIND_PHASE);
			else if (ends_with(KW_FRQ, 4)) open_number(KIND_FREQ);
			else if (ends_with(KW_AMP, 4)) open_number(KIND_AMPL);
			else if (ends_with(KW_OFST, 5)) open_number(KIND_OFST);
			else if (ends_with(KW_ON, 2)) add_write(KIND_OUTEN, 1);
			else if (ends_with(KW_OFF, 3)) add_write(KIND_OUTEN, 0);
			else found = 0;
			if (found) begin
				prog = 0;
				wave_armed = arm;
			end
		end
		if (it.end_of_message) begin
			if (num_on && byte_writes.size() < 2) close_number();
			reset_message();
		end
		for (int i = 0; i < byte_writes.size(); i++) begin
			w = byte_writes[i];
			w.final_result = (i == byte_writes.size() - 1);
			parser_writes.push_back(w);
		end
	endtask

	task automatic check_write(out_item_t got);
		out_item_t want;
		writes_seen++;
		if (parser_writes.size() == 0) begin
			$error("write with none expected: kind %0d channel %0d value %0d",
				got.kind, got.channel, got.value);
			error_count++;
			return;
		end
		want = parser_writes.pop_front();
		if (got.kind !== want.kind) begin
			$error("kind: expected %0d, actual %0d", want.kind, got.kind);
			error_count++;
		end
		if (got.channel !== want.channel) begin
			$error("channel: expected %0d, actual %0d", want.channel, got.channel);
			error_count++;
		end
		if (got.value !== want.value) begin
			$error("value: expected %0d, actual %0d", want.value, got.value);
			error_count++;
		end
		if (got.final_result !== want.final_result) begin
			$error("final_result: expected %0d, actual %0d",
				want.final_result, got.final_result);
			error_count++;
		end
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
	endtask

	task automatic add_digit();
		msg.push_back(8'("0" + $urandom_range(9)));
	endtask

	// signed decimal, sometimes long enough to saturate, sometimes malformed
	task automatic add_number();
		int nd;
		if ($urandom_range(3) == 0) msg.push_back("-");
		nd = ($urandom_range(7) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 5);
		repeat (nd) add_digit();
		if ($urandom_range(1)) begin
			msg.push_back(".");
			repeat ($urandom_range(0, 5)) add_digit();
			if ($urandom_range(5) == 0) msg.push_back(".");
		end
	endtask

	task automatic add_segment();
		string s;
		case ($urandom_range(15))
			0: add_text("C1:");
			1: add_text("C2:");
			2, 3: add_text("WVTP,SINE,");
			4: begin
				add_text("WVTP,");
				add_text(wave_names[$urandom_range(2)]);
			end
			5: add_text("OUTP ON");
			6: add_text("OUTP OFF");
			7: begin add_text("PHSE,"); add_number(); end
			8: begin add_text("FRQ,"); add_number(); end
			9: begin add_text("AMP,"); add_number(); end
			10: begin add_text("OFST,"); add_number(); end
			11: repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom_range(255)));
			12: begin
				// truncated keyword
				s = kw_text[$urandom_range(11)];
				add_text(s.substr(0, $urandom_range(s.len() - 2)));
			end
			13: add_text($urandom_range(1) ? "BSWV?" : "IDN-SGLT-PRI?");
			14: begin
				// minus sign in the middle of a number
				add_text("OFST,");
				add_digit();
				msg.push_back("-");
				add_digit();
			end
			default: msg.push_back(seps[$urandom_range(3)]);
		endcase
		if ($urandom_range(1)) msg.push_back(seps[$urandom_range(3)]);
	endtask

	task automatic end_message();
		in_item_t it;
		for (int i = 0; i < msg.size(); i++) begin
			it.char_in = msg[i];
			it.end_of_message = (i == msg.size() - 1);
			cmd_bytes.push_back(it);
		end
		msg.delete();
		msg_count++;
	endtask

	// command side: offers queued bytes, idling according to the phase
	always @(posedge clk) begin : cmd_driver
		int idle_pct;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				parse_byte(cmd);
				bytes_sent++;
			end
			if (bytes_sent >= 2 * total_bytes / 3) idle_phase <= PHASE_NO_IDLE;
			else if (bytes_sent >= total_bytes / 3) idle_phase <= PHASE_TX_BUSY;
			idle_pct = (idle_phase == PHASE_RX_BUSY) ? 31 :
				(idle_phase == PHASE_TX_BUSY) ? 53 : 0;
			if (!cmd_valid || !cmd_stall) begin
				if (cmd_bytes.size() > 0 && $urandom_range(99) >= idle_pct) begin
					cmd <= cmd_bytes.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// result side: checks each transfer, stalls at random and once for a long stretch
	always @(posedge clk) begin : res_monitor
		int idle_pct;
		int hold_left;
		bit hold_done;
		if (arst_n) begin
			if (res_valid && !res_stall) check_write(res);
			idle_pct = (idle_phase == PHASE_RX_BUSY) ? 53 :
				(idle_phase == PHASE_TX_BUSY) ? 31 : 0;
			if (idle_phase == PHASE_NO_IDLE && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(99) < idle_pct);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		res_stall = 1'b0;
		idle_phase = PHASE_RX_BUSY;
		reset_message();

		// directed: channel 2 sine and output on, saturated negative amplitude
		// closed by the end of the message, wave query muting the rest
		add_text("C2:WVTP,SINE,ON");
		end_message();
		add_text("AMP,-9999999");
		end_message();
		add_text("BSWV?");
		msg.push_back(8'hFF);
		end_message();

		while (cmd_bytes.size() < RANDOM_BYTES + 33) begin
			repeat ($urandom_range(1, 5)) add_segment();
			end_message();
		end
		total_bytes = cmd_bytes.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_sent != total_bytes || parser_writes.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d command bytes in %0d messages, %0d parser writes checked",
			total_bytes, msg_count, writes_seen);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
